// ===== src/backward_lz_bitstream_depacker_macros.svh =====
// Assertion macros shared by the depacker checker
`ifndef BACKWARD_LZ_BITSTREAM_DEPACKER_MACROS_SVH
`define BACKWARD_LZ_BITSTREAM_DEPACKER_MACROS_SVH

// same-cycle implication, quiet during reset
`define BLZ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("depacker assertion failed");

// next-cycle implication, quiet during reset
`define BLZ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("depacker assertion failed");

// next-cycle implication that also holds across reset
`define BLZ_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("depacker assertion failed");

`endif

// ===== src/blz_pkg.sv =====
// Shared types and constants of the backward LZ depacker
package blz_pkg;
    localparam int HIST_DEPTH = 32768;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int FIELD_W    = 15;
    localparam int POS_W      = 24;

    typedef enum logic [2:0] {
        ST_ACC  = 3'd0,
        ST_REJ  = 3'd1,
        ST_OUT  = 3'd2,
        ST_NEED = 3'd3,
        ST_FIN  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_SKIP_START = 4'd0,
        PH_SKIP       = 4'd1,
        PH_FLAG       = 4'd2,
        PH_LITLEN     = 4'd3,
        PH_LIT        = 4'd4,
        PH_MIDX       = 4'd5,
        PH_MSEL       = 4'd6,
        PH_MOFF       = 4'd7,
        PH_MLEN       = 4'd8,
        PH_COPY       = 4'd9,
        PH_DONE       = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        C_CLEAR,
        C_IDLE,
        C_RUN,
        C_RD
    } ctl_t;

    typedef enum logic [2:0] {
        REG_OW0    = 3'd0,
        REG_OW1    = 3'd1,
        REG_OW2    = 3'd2,
        REG_OW3    = 3'd3,
        REG_SKIP   = 3'd4,
        REG_LENGTH = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic       is_load;
        logic [7:0] data;
    } item_t;
endpackage

// ===== src/blz_front.sv =====
// Input queue: takes beats, classifies them and holds up to two for the decoder
module blz_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    output logic          q_valid,
    input  logic          q_ready,
    output blz_pkg::item_t q_item
);
    import blz_pkg::*;

    item_t      slot_reg [2];
    item_t      slot_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[0];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    // slot 0 is the head; shift on pop
    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (pop)
            slot_next[0] = slot_reg[1];
        if (push) begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
                slot_next[0] = '{is_load: !s_tuser, data: s_tdata};
            else
                slot_next[1] = '{is_load: !s_tuser, data: s_tdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end
endmodule

// ===== src/blz_core.sv =====
// Decoder: bit-serial stream parser, history memory and result register
module blz_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_addr,
    input  logic [blz_pkg::POS_W-1:0]  cfg_wr_data,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  blz_pkg::item_t             q_item,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast
);
    import blz_pkg::*;

    logic [3:0]         ow0_reg, ow1_reg, ow2_reg, ow3_reg;
    logic [4:0]         skip_reg;

    ctl_t               ctl_reg, ctl_next;
    phase_t             ph_reg, ph_next;
    logic [HIST_AW-1:0] clr_reg, clr_next;
    logic [7:0]         bbuf_reg, bbuf_next;
    logic [3:0]         brem_reg, brem_next;
    logic [FIELD_W-1:0] fval_reg, fval_next;
    logic [4:0]         fleft_reg, fleft_next;
    logic [POS_W-1:0]   run_reg, run_next;
    logic [FIELD_W-1:0] moff_reg, moff_next;
    logic [1:0]         midx_reg, midx_next;
    logic [POS_W-1:0]   wpos_reg, wpos_next;

    logic [7:0]         mem [HIST_DEPTH];
    logic [7:0]         rdata_reg;
    logic [HIST_AW-1:0] rd_addr;

    logic               ov_reg;
    status_t            ost_reg;
    logic [7:0]         obyte_reg;
    logic [POS_W-1:0]   opos_reg;
    logic               olast_reg;

    logic               res_valid, out_free, stall, pop;
    status_t            res_status;
    logic [7:0]         res_byte;
    logic               mem_we, do_emit;
    logic [HIST_AW-1:0] mem_waddr;
    logic [7:0]         mem_wdata, emit_b;
    logic [POS_W-1:0]   wpos_m1;
    logic [POS_W:0]     run_sum;
    logic [2:0]         grp;

    assign out_free = !ov_reg || m_tready;
    assign stall    = res_valid && !out_free;
    assign q_ready  = pop && !stall;
    assign wpos_m1  = wpos_reg - POS_W'(1);
    assign rd_addr  = wpos_reg[HIST_AW-1:0] + moff_reg[HIST_AW-1:0];

    always_comb begin
        ctl_next   = ctl_reg;
        ph_next    = ph_reg;
        clr_next   = clr_reg;
        bbuf_next  = bbuf_reg;
        brem_next  = brem_reg;
        fval_next  = fval_reg;
        fleft_next = fleft_reg;
        run_next   = run_reg;
        moff_next  = moff_reg;
        midx_next  = midx_reg;
        wpos_next  = wpos_reg;
        res_valid  = 1'b0;
        res_status = ST_ACC;
        res_byte   = 8'd0;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = wpos_m1[HIST_AW-1:0];
        mem_wdata  = 8'd0;
        do_emit    = 1'b0;
        emit_b     = 8'd0;
        // LITLEN groups are 2 bits, MLEN groups 3 bits
        grp        = (ph_reg == PH_LITLEN) ? {1'b0, fval_reg[1:0]} : fval_reg[2:0];
        run_sum    = {1'b0, run_reg} + (POS_W+1)'(grp);

        unique case (ctl_reg)
            C_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + HIST_AW'(1);
                if (clr_reg == HIST_AW'(HIST_DEPTH - 1))
                    ctl_next = C_IDLE;
            end
            C_IDLE: begin
                if (q_valid) begin
                    pop = 1'b1;
                    if (q_item.is_load) begin
                        res_valid = 1'b1;
                        if (brem_reg == 4'd0) begin
                            bbuf_next  = q_item.data;
                            brem_next  = 4'd8;
                            res_status = ST_ACC;
                        end else begin
                            res_status = ST_REJ;
                        end
                    end else begin
                        ctl_next = C_RUN;
                        if (ph_reg != PH_DONE && wpos_reg == '0)
                            ph_next = PH_DONE;
                    end
                end
            end
            C_RUN: begin
                priority if (ph_reg == PH_DONE) begin
                    res_valid  = 1'b1;
                    res_status = ST_FIN;
                    ctl_next   = C_IDLE;
                end else if (ph_reg == PH_SKIP_START) begin
                    ph_next    = PH_SKIP;
                    fval_next  = '0;
                    fleft_next = skip_reg;
                end else if (ph_reg == PH_COPY) begin
                    ctl_next = C_RD;    // read issued at rd_addr this cycle
                end else if (fleft_reg != 5'd0) begin
                    if (brem_reg == 4'd0) begin
                        res_valid  = 1'b1;
                        res_status = ST_NEED;
                        ctl_next   = C_IDLE;
                    end else begin
                        fval_next  = {fval_reg[FIELD_W-2:0], bbuf_reg[0]};
                        bbuf_next  = {1'b0, bbuf_reg[7:1]};
                        brem_next  = brem_reg - 4'd1;
                        fleft_next = fleft_reg - 5'd1;
                    end
                end else begin
                    fval_next = '0;
                    unique case (ph_reg)
                        PH_SKIP: begin
                            ph_next = PH_FLAG; fleft_next = 5'd1;
                        end
                        PH_FLAG: begin
                            fleft_next = 5'd2;
                            if (fval_reg == '0) begin
                                run_next = '0;
                                ph_next  = PH_LITLEN;
                            end else begin
                                ph_next = PH_MIDX;
                            end
                        end
                        PH_LITLEN, PH_MLEN: begin
                            run_next = run_sum[POS_W] ? '1 : run_sum[POS_W-1:0];
                            if (ph_reg == PH_LITLEN) begin
                                if (grp == 3'd3) fleft_next = 5'd2;
                                else begin
                                    ph_next = PH_LIT; fleft_next = 5'd8;
                                end
                            end else begin
                                if (grp == 3'd7) fleft_next = 5'd3;
                                else ph_next = PH_COPY;
                            end
                        end
                        PH_LIT: begin
                            do_emit  = 1'b1;
                            emit_b   = fval_reg[7:0];
                            ctl_next = C_IDLE;
                            if (run_reg == '0) begin
                                ph_next = PH_MIDX; fleft_next = 5'd2;
                            end else begin
                                run_next   = run_reg - POS_W'(1);
                                fleft_next = 5'd8;
                            end
                        end
                        PH_MIDX: begin
                            midx_next = fval_reg[1:0];
                            run_next  = POS_W'(fval_reg[1:0]) + POS_W'(1);
                            unique case (fval_reg[1:0])
                                2'd0: begin ph_next = PH_MOFF; fleft_next = {1'b0, ow0_reg}; end
                                2'd1: begin ph_next = PH_MOFF; fleft_next = {1'b0, ow1_reg}; end
                                2'd2: begin ph_next = PH_MOFF; fleft_next = {1'b0, ow2_reg}; end
                                default: begin ph_next = PH_MSEL; fleft_next = 5'd1; end
                            endcase
                        end
                        PH_MSEL: begin
                            ph_next    = PH_MOFF;
                            fleft_next = (fval_reg == '0) ? 5'd7 : {1'b0, ow3_reg};
                        end
                        PH_MOFF: begin
                            moff_next = fval_reg;
                            if (midx_reg == 2'd3) begin
                                ph_next = PH_MLEN; fleft_next = 5'd3;
                            end else begin
                                ph_next = PH_COPY;
                            end
                        end
                        default: ph_next = PH_DONE;
                    endcase
                end
            end
            C_RD: begin
                do_emit  = 1'b1;
                emit_b   = rdata_reg;
                ctl_next = C_IDLE;
                if (run_reg == '0) begin
                    ph_next = PH_FLAG; fval_next = '0; fleft_next = 5'd1;
                end else begin
                    run_next = run_reg - POS_W'(1);
                end
            end
            default: ctl_next = C_IDLE;
        endcase

        if (do_emit) begin
            mem_we     = 1'b1;
            mem_wdata  = emit_b;
            wpos_next  = wpos_m1;
            res_valid  = 1'b1;
            res_status = ST_OUT;
            res_byte   = emit_b;
            if (wpos_m1 == '0)
                ph_next = PH_DONE;    // overshoot of the run is dropped
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (mem_we && !stall)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ow0_reg   <= 4'd9;
            ow1_reg   <= 4'd10;
            ow2_reg   <= 4'd12;
            ow3_reg   <= 4'd13;
            skip_reg  <= 5'd0;
            ctl_reg   <= C_CLEAR;
            ph_reg    <= PH_SKIP_START;
            clr_reg   <= '0;
            bbuf_reg  <= 8'd0;
            brem_reg  <= 4'd0;
            fval_reg  <= '0;
            fleft_reg <= 5'd0;
            run_reg   <= '0;
            moff_reg  <= '0;
            midx_reg  <= 2'd0;
            wpos_reg  <= POS_W'(1);
            ov_reg    <= 1'b0;
        end else begin
            if (!stall) begin
                ctl_reg  <= ctl_next;
                clr_reg  <= clr_next;
                bbuf_reg <= bbuf_next;
                brem_reg <= brem_next;
            end
            // a length write restarts decoding at the skip phase
            if (cfg_wr_en && cfg_addr == REG_LENGTH) begin
                wpos_reg  <= cfg_wr_data;
                ph_reg    <= PH_SKIP_START;
                fval_reg  <= '0;
                fleft_reg <= 5'd0;
                run_reg   <= '0;
                moff_reg  <= '0;
                midx_reg  <= 2'd0;
            end else if (!stall) begin
                ph_reg    <= ph_next;
                fval_reg  <= fval_next;
                fleft_reg <= fleft_next;
                run_reg   <= run_next;
                moff_reg  <= moff_next;
                midx_reg  <= midx_next;
                wpos_reg  <= wpos_next;
            end
            if (out_free)
                ov_reg <= res_valid;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_OW0:  ow0_reg  <= cfg_wr_data[3:0];
                    REG_OW1:  ow1_reg  <= cfg_wr_data[3:0];
                    REG_OW2:  ow2_reg  <= cfg_wr_data[3:0];
                    REG_OW3:  ow3_reg  <= cfg_wr_data[3:0];
                    REG_SKIP: skip_reg <= cfg_wr_data[4:0];
                    default: ;
                endcase
            end
        end
        if (out_free && res_valid) begin
            ost_reg   <= res_status;
            obyte_reg <= res_byte;
            opos_reg  <= (res_status == ST_OUT) ? wpos_m1 : '0;
            olast_reg <= (res_status == ST_OUT) && (wpos_m1 == '0);
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = ost_reg;
    assign m_tdata  = {opos_reg, obyte_reg};
    assign m_tlast  = olast_reg;
endmodule

// ===== src/backward_lz_bitstream_depacker.sv =====
// Backward LZ bitstream depacker, top level
// Usage:
//   s_ channel: one beat per command. s_tuser=0 loads s_tdata[7:0] as the next
//   packed byte (taken from the file end backward, LSB first); s_tuser=1 asks
//   for the next output byte. Every beat returns exactly one m_ beat.
//   m_ channel: m_tuser is the status (accepted, rejected, output valid, needs
//   input, finished); m_tdata holds the byte and its position when the status
//   is output valid; m_tlast marks position zero.
//   cfg port: write enable, register index and data; write only while idle.
// Operation:
//   A load is answered from the idle state through the output register. A
//   request passes from idle into the parser, which takes the stream bit by
//   bit and steps field by field; a copy goes through the registered history
//   read. One item is in the decoder at a time.
// Reset:
//   After aresetn the 32768-entry history memory is cleared, one entry per
//   cycle; the input queue takes up to two beats meanwhile and the rest wait.
//   Configuration writes are taken during the clear.
// Stall: a two-beat input queue and the output register decouple the sides;
//   while a result waits on a full, unready output, the decoder holds its state.
module backward_lz_bitstream_depacker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_addr,
    input  logic [blz_pkg::POS_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // packed_byte
    input  logic                      s_tuser,   // cmd
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // out_byte, out_position
    output logic [2:0]                m_tuser,   // status
    output logic                      m_tlast
);
    import blz_pkg::*;

    logic  q_valid, q_ready;
    item_t q_item;

    blz_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    blz_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );
endmodule

// ===== src/blz_checker.sv =====
// Port-level checks of the depacker and their bind
`include "backward_lz_bitstream_depacker_macros.svh"
module blz_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import blz_pkg::*;

    `BLZ_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `BLZ_ASSERT_IMP(a_last_is_out, aclk, aresetn, m_tvalid && m_tlast, m_tuser == ST_OUT && m_tdata[31:8] == 24'd0)
    `BLZ_ASSERT_IMP(a_no_data, aclk, aresetn, m_tvalid && m_tuser != ST_OUT, m_tdata == 32'd0 && !m_tlast)
    `BLZ_ASSERT_ALW(a_reset_quiet, aclk, !aresetn, !m_tvalid)
endmodule

bind backward_lz_bitstream_depacker blz_checker u_blz_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the backward LZ bitstream depacker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import blz_pkg::*;

    typedef struct {
        status_t     st;
        logic [7:0]  byte_val;
        logic [23:0] pos;
        logic        lst;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // packed_byte
    logic        s_tuser = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // out_byte, out_position
    logic [2:0]  m_tuser;        // status
    logic        m_tlast;

    backward_lz_bitstream_depacker i_dut (.*);

    initial forever #1 aclk = ~aclk;

    item_t   pend_q[$];
    result_t result_q[$];
    int      errors = 0;
    int      results_seen = 0;
    bit      calm = 1'b0;

    // decoder mirror
    logic [3:0]  ow[4];
    logic [4:0]  skip_cnt;
    logic [23:0] ulen;
    logic [7:0]  bbuf;
    int          bleft;
    phase_t      phase;
    logic [14:0] fval;
    int          fleft;
    logic [23:0] run_len;
    logic [14:0] moff;
    logic [1:0]  midx;
    logic [23:0] wpos;
    logic [7:0]  ring[HIST_DEPTH];

    task automatic start_field(phase_t ph, int n);
        phase = ph;
        fval = '0;
        fleft = n;
    endtask

    function automatic bit fill_field();
        while (fleft > 0) begin
            if (bleft == 0) return 1'b0;
            fval = {fval[13:0], bbuf[0]};
            bbuf = bbuf >> 1;
            bleft--;
            fleft--;
        end
        return 1'b1;
    endfunction

    task automatic grow_run(logic [23:0] v);
        logic [24:0] s;
        s = run_len + v;
        run_len = s[24] ? 24'hFFFFFF : s[23:0];
    endtask

    // writes one byte one position down; returns 1 once position zero is written
    function automatic bit put_byte(logic [7:0] b, ref result_t r);
        logic [23:0] p;
        p = wpos - 24'd1;
        ring[p[14:0]] = b;
        wpos = p;
        r.st = ST_OUT;
        r.byte_val = b;
        r.pos = p;
        r.lst = (p == 0);
        if (p == 0) begin
            phase = PH_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic decode_item(item_t it, output result_t r);
        logic [24:0] src;
        r = '{ST_ACC, 8'd0, 24'd0, 1'b0};
        if (it.is_load) begin
            if (bleft == 0) begin
                bbuf = it.data;
                bleft = 8;
            end else begin
                r.st = ST_REJ;
            end
            return;
        end
        if (phase != PH_DONE && wpos == 0) phase = PH_DONE;
        forever begin
            case (phase)
                PH_DONE: begin
                    r.st = ST_FIN;
                    return;
                end
                PH_SKIP_START: begin
                    start_field(PH_SKIP, skip_cnt);
                    continue;
                end
                PH_COPY: begin
                    src = wpos + moff;
                    if (!put_byte(ring[src[14:0]], r)) begin
                        if (run_len == 0) start_field(PH_FLAG, 1);
                        else run_len--;
                    end
                    return;
                end
                default: ;
            endcase
            if (!fill_field()) begin
                r.st = ST_NEED;
                return;
            end
            case (phase)
                PH_SKIP: start_field(PH_FLAG, 1);
                PH_FLAG: begin
                    if (fval == 0) begin
                        run_len = '0;
                        start_field(PH_LITLEN, 2);
                    end else begin
                        start_field(PH_MIDX, 2);
                    end
                end
                PH_LITLEN: begin
                    grow_run(24'(fval[1:0]));
                    if (fval[1:0] == 2'd3) start_field(PH_LITLEN, 2);
                    else start_field(PH_LIT, 8);
                end
                PH_LIT: begin
                    if (!put_byte(fval[7:0], r)) begin
                        if (run_len == 0) begin
                            start_field(PH_MIDX, 2);
                        end else begin
                            run_len--;
                            start_field(PH_LIT, 8);
                        end
                    end
                    return;
                end
                PH_MIDX: begin
                    midx = fval[1:0];
                    run_len = midx + 24'd1;
                    if (midx == 2'd3) start_field(PH_MSEL, 1);
                    else start_field(PH_MOFF, ow[midx]);
                end
                PH_MSEL: start_field(PH_MOFF, fval == 0 ? 7 : ow[3]);
                PH_MOFF: begin
                    moff = fval;
                    if (midx == 2'd3) start_field(PH_MLEN, 3);
                    else phase = PH_COPY;
                end
                PH_MLEN: begin
                    grow_run(24'(fval[2:0]));
                    if (fval[2:0] == 3'd7) start_field(PH_MLEN, 3);
                    else phase = PH_COPY;
                end
                default: phase = PH_DONE;
            endcase
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_OW0: ow[0] = val[3:0];
            REG_OW1: ow[1] = val[3:0];
            REG_OW2: ow[2] = val[3:0];
            REG_OW3: ow[3] = val[3:0];
            REG_SKIP: skip_cnt = val[4:0];
            REG_LENGTH: begin
                ulen = val;
                wpos = val;
                phase = PH_SKIP_START;
                fval = '0;
                fleft = 0;
                run_len = '0;
                moff = '0;
                midx = '0;
            end
            default: ;
        endcase
    endtask

    task automatic set_all(logic [3:0] w0, logic [3:0] w1, logic [3:0] w2, logic [3:0] w3,
                           logic [4:0] sk, logic [23:0] len);
        write_reg(REG_OW0, w0);
        write_reg(REG_OW1, w1);
        write_reg(REG_OW2, w2);
        write_reg(REG_OW3, w3);
        write_reg(REG_SKIP, sk);
        write_reg(REG_LENGTH, len);
    endtask

    task automatic queue_item(bit is_req, logic [7:0] b);
        item_t   it;
        result_t r;
        it.is_load = ~is_req;
        it.data = b;
        decode_item(it, r);
        pend_q.insert(pend_q.size(), it);
        result_q.insert(result_q.size(), r);
    endtask

    // mostly loads into an empty buffer and mostly requests while bits remain
    task automatic queue_stream(int n, int byte_mode);
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            case (byte_mode)
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = (k % 2) ? 8'hAA : 8'h55;
                default: b = $urandom_range(0, 255);
            endcase
            if (bleft == 0) queue_item($urandom_range(0, 9) == 0, b);
            else queue_item($urandom_range(0, 9) != 0, b);
        end
    endtask

    task automatic drain();
        while (result_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // input side
    int in_gap = 0;
    always @(posedge aclk) begin
        item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                it = pend_q[0];
                pend_q.delete(0);
                s_tvalid <= 1'b1;
                s_tuser <= ~it.is_load;
                s_tdata <= it.data;
                if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off once enough beats have passed
    int long_hold = 0;
    bit held = 1'b0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!held && results_seen >= 120) begin
                held <= 1'b1;
                long_hold <= 300;
            end else if (long_hold > 0) begin
                long_hold <= long_hold - 1;
            end
        end
    end

    // output side
    int out_gap = 0;
    always @(posedge aclk) begin
        result_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tuser, 0);
                end else begin
                    w = result_q[0];
                    result_q.delete(0);
                    if (m_tuser !== w.st) report_mismatch("status", m_tuser, w.st);
                    if (m_tdata[7:0] !== w.byte_val)
                        report_mismatch("out_byte", m_tdata[7:0], w.byte_val);
                    if (m_tdata[31:8] !== w.pos)
                        report_mismatch("out_position", m_tdata[31:8], w.pos);
                    if (m_tlast !== w.lst) report_mismatch("last", m_tlast, w.lst);
                end
            end
            if (long_hold > 0) begin
                m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        ow = '{4'd9, 4'd10, 4'd12, 4'd13};
        skip_cnt = '0;
        ulen = 24'd1;
        wpos = 24'd1;
        bbuf = '0;
        bleft = 0;
        phase = PH_SKIP_START;
        fval = '0;
        fleft = 0;
        run_len = '0;
        moff = '0;
        midx = '0;
        foreach (ring[i]) ring[i] = 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, zero widths, widest fields, zero length
        queue_stream(6, 0);
        drain();
        set_all(4'd0, 4'd0, 4'd0, 4'd0, 5'd0, 24'd12);
        queue_stream(8, 2);
        drain();
        set_all(4'd15, 4'd15, 4'd15, 4'd15, 5'd31, 24'hFFFFFF);
        queue_stream(8, 1);
        drain();
        set_all(4'd1, 4'd2, 4'd3, 4'd4, 5'd1, 24'd0);
        queue_item(1'b1, 8'h00);
        queue_item(1'b0, 8'h00);
        queue_item(1'b0, 8'hFF);
        drain();

        // random streams with random settings
        for (int ph = 0; ph < 14; ph++) begin
            if (ph >= 12) calm = 1'b1;
            set_all($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom_range(0, 31),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                                : $urandom_range(1, 300));
            queue_stream(55, $urandom_range(0, 19) == 0 ? $urandom_range(0, 2) : 3);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== backward_lz_bitstream_depacker.f =====
+incdir+src
src/blz_pkg.sv
src/blz_front.sv
src/blz_core.sv
src/backward_lz_bitstream_depacker.sv
src/blz_checker.sv
verif/tb_top.sv
